@@ hdl/ssba_pkg.sv @@
// Shared types and constants for the swap slot bitmap allocator.
// No dependencies.
package ssba_pkg;

    localparam int OP_W    = 2;
    localparam int SLOT_W  = 10;
    localparam int FREE_W  = 11;
    localparam int BYTE_W  = 8;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [BYTE_W-1:0] t_byte;

    localparam t_op OP_ALLOC   = 2'd0;
    localparam t_op OP_MARK    = 2'd1;
    localparam t_op OP_RELEASE = 2'd2;

    localparam t_byte BYTE_FULL = 8'hFF;

endpackage

@@ hdl/ssba_ram.sv @@
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module ssba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/swap_slot_bitmap_allocator.sv @@
// Swap slot bitmap allocator: bitmap in ssba_ram, one byte per word; uses ssba_pkg.
// Allocate: scans bytes from 0, one RAM read per cycle, and gives its result at the first
// byte that is not full.
// Mark and release: read-modify-write of one byte; full-map allocate and no-ops answer from idle.
// One beat in flight: busy drops in the result cycle, next accept at the end of that cycle;
// the receiver cannot stall. Reset clears every byte of the map, busy high.
module swap_slot_bitmap_allocator
    import ssba_pkg::*;
#(
    parameter int NUM_SLOTS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  t_op               i_op,
    input  t_slot             i_slot,
    output logic              busy,
    output logic              o_strobe,
    output t_slot             o_granted_slot,
    output logic              o_status,
    output logic [FREE_W-1:0] o_free_left
);

    localparam int DEPTH = (NUM_SLOTS + 7) / 8;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = $clog2(NUM_SLOTS + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_MRD  = 3'd3;
    localparam logic [2:0] ST_MCHK = 3'd4;

    logic [2:0]        r_state;
    logic [AW-1:0]     r_raddr;
    logic [AW-1:0]     r_daddr;
    logic              r_dval;
    t_op               r_op;
    t_slot             r_slot;
    logic [FW-1:0]     r_free;
    logic [FW-1:0]     n_free;
    logic              r_strobe;
    t_slot             r_granted;
    logic              r_status;
    logic [FREE_W-1:0] r_free_out;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    t_byte             w_wdata;
    t_byte             w_rdata;
    logic [2:0]        w_bit;
    logic              w_full;
    t_byte             w_mask;
    logic              w_used;
    logic [31:0]       w_found;
    logic [31:0]       w_idx;
    logic              w_in_range;

    ssba_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_bit = 3'd0;
        for (int b = BYTE_W - 1; b >= 0; b--) begin
            if (!w_rdata[b]) begin
                w_bit = 3'(b);
            end
        end
    end

    assign w_full     = (w_rdata == BYTE_FULL);
    assign w_mask     = t_byte'(1) << r_slot[2:0];
    assign w_used     = |(w_rdata & w_mask);
    assign w_found    = 32'({r_daddr, w_bit});
    assign w_idx      = 32'(i_slot >> 3);
    assign w_in_range = (32'(i_slot) < 32'(NUM_SLOTS));

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_daddr;
        w_wdata = w_rdata;
        n_free  = r_free;
        unique case (r_state)
            ST_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_raddr;
                w_wdata = '0;
            end
            ST_SCAN: begin
                if (r_dval && !w_full) begin
                    w_we    = 1'b1;
                    w_wdata = w_rdata | (t_byte'(1) << w_bit);
                    n_free  = r_free - FW'(1);
                end
            end
            ST_MCHK: begin
                if (r_op == OP_MARK && !w_used) begin
                    w_we    = 1'b1;
                    w_wdata = w_rdata | w_mask;
                    n_free  = r_free - FW'(1);
                end else if (r_op == OP_RELEASE && w_used) begin
                    w_we    = 1'b1;
                    w_wdata = w_rdata & ~w_mask;
                    n_free  = r_free + FW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_daddr <= r_raddr;
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_raddr  <= '0;
            r_dval   <= 1'b0;
            r_free   <= FW'(NUM_SLOTS);
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_free   <= n_free;
            unique case (r_state)
                ST_CLR: begin
                    if (r_raddr == LAST) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_raddr <= r_raddr + AW'(1);
                    end
                end
                ST_IDLE: begin
                    if (start) begin
                        r_op   <= i_op;
                        r_slot <= i_slot;
                        priority if (i_op == OP_ALLOC && r_free != '0) begin
                            r_state <= ST_SCAN;
                            r_raddr <= '0;
                            r_dval  <= 1'b0;
                        end else if (i_op == OP_ALLOC) begin
                            r_strobe   <= 1'b1;
                            r_granted  <= '0;
                            r_status   <= 1'b1;
                            r_free_out <= FREE_W'(32'(r_free));
                        end else if ((i_op == OP_MARK || i_op == OP_RELEASE) && w_in_range) begin
                            r_state <= ST_MRD;
                            r_raddr <= w_idx[AW-1:0];
                        end else begin
                            r_strobe   <= 1'b1;
                            r_granted  <= i_slot;
                            r_status   <= 1'b0;
                            r_free_out <= FREE_W'(32'(r_free));
                        end
                    end
                end
                ST_SCAN: begin
                    r_dval <= 1'b1;
                    if (r_raddr != LAST) begin
                        r_raddr <= r_raddr + AW'(1);
                    end
                    if (r_dval && !w_full) begin
                        r_state    <= ST_IDLE;
                        r_strobe   <= 1'b1;
                        r_granted  <= w_found[SLOT_W-1:0];
                        r_status   <= 1'b0;
                        r_free_out <= FREE_W'(32'(n_free));
                    end else if (r_dval && r_daddr == LAST) begin
                        r_state    <= ST_IDLE;
                        r_strobe   <= 1'b1;
                        r_granted  <= '0;
                        r_status   <= 1'b1;
                        r_free_out <= FREE_W'(32'(r_free));
                    end
                end
                ST_MRD: begin
                    r_state <= ST_MCHK;
                end
                ST_MCHK: begin
                    r_state    <= ST_IDLE;
                    r_strobe   <= 1'b1;
                    r_granted  <= r_slot;
                    r_status   <= 1'b0;
                    r_free_out <= FREE_W'(32'(n_free));
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_strobe       = r_strobe;
    assign o_granted_slot = r_granted;
    assign o_status       = r_status;
    assign o_free_left    = r_free_out;

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status) |-> (o_granted_slot == '0))
        else $error("failed allocate returned a nonzero slot");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_free) <= 32'(NUM_SLOTS))
        else $error("free count above slot count");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR) |-> !o_strobe)
        else $error("result beat during clearing pass");

    a_free_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_SCAN && r_state != ST_MCHK) |=> $stable(r_free))
        else $error("free count moved outside a map update");

endmodule
